/* src/hbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types and constants of the static Huffman byte compressor.
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam int WEIGHT_W = 32;
  localparam int NODE_W   = 9;
  localparam int DEPTH_W  = 8;
  localparam int LEN_W    = 6;
  localparam int LEN_CAP  = 40;
  localparam int LEAF_IDS = 256;

  localparam logic [1:0] KIND_COUNT  = 2'd0;
  localparam logic [1:0] KIND_BUILD  = 2'd1;
  localparam logic [1:0] KIND_ENCODE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } hbc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] pad_bits;
    logic [1:0] status;
    logic       last;
  } hbc_out_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   node;
  } hbc_heap_t;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
    logic [2:0] pad;
  } hbc_build_res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } hbc_emit_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CNT_RD, S_CNT_WR, S_BUILD, S_BUILD_OUT, S_ENC_RD, S_ENC_GO, S_ENC_RUN
  } top_state_t;

  typedef enum logic [4:0] {
    B_IDLE, B_LOAD_RD, B_LOAD_WR, B_LOAD_END,
    H_START, H_RD_I, H_WT_I, H_CHK, H_RD_R, H_CMP, H_PLACE,
    M_CHECK, M_POP1, M_POP2, M_SECOND, M_INS,
    T_START, T_ROOT, T_POP, T_VISIT, T_KIDS, T_PUSH_R, T_PUSH_L, T_LEAF_RD, T_LEAF, T_END,
    C_CLEAR, B_DONE
  } bld_state_t;

  typedef enum logic {
    P_IDLE, P_SHIFT
  } pk_state_t;

endpackage
`default_nettype wire

/* src/hbc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/hbc_build.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_build
// Code builder: loads the histogram into a min-heap, merges minima into a
// tree, walks the tree to assign codes and works out the front padding.
// ----------------------------------------------------------------------------
module hbc_build import hbc_pkg::*; #(
  parameter int SYMBOLS     = 256,
  parameter int COUNT_WIDTH = 32,
  parameter int LEN_LIMIT   = 32,
  localparam int SAW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1,
  localparam int CW  = LEN_LIMIT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic [SAW-1:0]         cnt_raddr,
  input  logic [COUNT_WIDTH-1:0] cnt_rdata,
  output logic                   code_we,
  output logic [SAW-1:0]         code_waddr,
  output logic [LEN_W+CW-1:0]    code_wdata,
  output hbc_build_res_t         res
);

  localparam int HAW    = $clog2(SYMBOLS + 1);
  localparam int INT_N  = SYMBOLS - 1;
  localparam int INT_AW = (INT_N > 1) ? $clog2(INT_N) : 1;
  localparam int STK_W  = NODE_W + DEPTH_W + CW;
  localparam int HEAP_W = $bits(hbc_heap_t);

  bld_state_t state, state_next;
  bld_state_t ret;

  logic [HAW-1:0]     n, i, p, sp;
  logic [SAW:0]       s;
  logic               second;
  hbc_heap_t          e, lch, l_ent, r_ent;
  logic [INT_AW-1:0]  nxt;
  logic [NODE_W-1:0]  cur_node;
  logic [DEPTH_W-1:0] cur_depth;
  logic [CW-1:0]      cur_code;
  logic               too_long;
  logic [2:0]         acc;
  logic [1:0]         res_status;
  logic [2:0]         res_pad;

  // heap memory
  logic               heap_we;
  logic [HAW-1:0]     heap_waddr, heap_raddr;
  hbc_heap_t          heap_wdata, heap_q;
  logic [HEAP_W-1:0]  heap_q_raw;

  // tree memory, one row per internal node
  logic [2*NODE_W-1:0] node_q;
  logic                node_we;

  // walk stack
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [STK_W-1:0]  stk_wdata, stk_q;
  logic [NODE_W-1:0] stk_node;
  logic [DEPTH_W-1:0] stk_depth;
  logic [CW-1:0]     stk_code;

  logic [HAW:0]      c2, c2p1;
  logic              has_l, has_r;
  logic              pick_r;
  hbc_heap_t         c_sel;
  logic [HAW-1:0]    c_pos;
  logic [HAW-1:0]    half;
  logic [WEIGHT_W:0] sum;
  logic [WEIGHT_W-1:0] sum_sat;
  logic [DEPTH_W-1:0] depth_inc;
  logic              last_sym;

  assign heap_q    = hbc_heap_t'(heap_q_raw);
  assign half      = n >> 1;
  assign c2        = {p, 1'b0};
  assign c2p1      = {p, 1'b1};
  assign has_l     = c2 <= {1'b0, n};
  assign has_r     = c2p1 <= {1'b0, n};
  // tie goes to the right child
  assign pick_r    = has_r && !(lch.weight < heap_q.weight);
  assign c_sel     = pick_r ? heap_q : lch;
  assign c_pos     = pick_r ? c2p1[HAW-1:0] : c2[HAW-1:0];
  assign sum       = {1'b0, l_ent.weight} + {1'b0, r_ent.weight};
  assign sum_sat   = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
  assign stk_node  = stk_q[STK_W-1 -: NODE_W];
  assign stk_depth = stk_q[CW +: DEPTH_W];
  assign stk_code  = stk_q[CW-1:0];
  assign depth_inc = cur_depth + DEPTH_W'(1);
  assign last_sym  = s == (SAW+1)'(SYMBOLS - 1);

  hbc_ram #(.WIDTH(HEAP_W), .DEPTH(SYMBOLS + 1)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_q_raw)
  );

  hbc_ram #(.WIDTH(2*NODE_W), .DEPTH(INT_N)) u_node (
    .clk(clk), .we(node_we), .waddr(nxt), .wdata({l_ent.node, r_ent.node}),
    .raddr(cur_node[INT_AW-1:0]), .rdata(node_q)
  );

  hbc_ram #(.WIDTH(STK_W), .DEPTH(SYMBOLS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (start) state_next = B_LOAD_RD;
      B_LOAD_RD:  state_next = B_LOAD_WR;
      B_LOAD_WR:  state_next = last_sym ? B_LOAD_END : B_LOAD_RD;
      B_LOAD_END: state_next = (n == '0) ? B_DONE : H_START;
      H_START:    state_next = (half == '0) ? ret : H_RD_I;
      H_RD_I:     state_next = H_WT_I;
      H_WT_I:     state_next = H_CHK;
      H_CHK:      state_next = has_l ? H_RD_R : H_PLACE;
      H_RD_R:     state_next = H_CMP;
      H_CMP:      state_next = (c_sel.weight < e.weight) ? H_CHK : H_PLACE;
      H_PLACE:    state_next = (i == HAW'(1)) ? ret : H_RD_I;
      M_CHECK:    state_next = (n > HAW'(1)) ? M_POP1 : T_START;
      M_POP1:     state_next = M_POP2;
      M_POP2:     state_next = H_START;
      M_SECOND:   state_next = M_POP1;
      M_INS:      state_next = H_START;
      T_START:    state_next = T_ROOT;
      T_ROOT:     state_next = T_POP;
      T_POP:      state_next = (sp == '0) ? T_END : T_VISIT;
      T_VISIT:    state_next = stk_node[NODE_W-1] ? T_KIDS : T_LEAF_RD;
      T_KIDS:     state_next = T_PUSH_R;
      T_PUSH_R:   state_next = T_PUSH_L;
      T_PUSH_L:   state_next = T_POP;
      T_LEAF_RD:  state_next = T_LEAF;
      T_LEAF:     state_next = T_POP;
      T_END:      state_next = too_long ? C_CLEAR : B_DONE;
      C_CLEAR:    state_next = last_sym ? B_DONE : C_CLEAR;
      B_DONE:     state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = p;
    heap_wdata = e;
    heap_raddr = i;
    node_we    = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = sp[SAW-1:0];
    stk_wdata  = {node_q[NODE_W-1:0], depth_inc, cur_code[CW-2:0], 1'b1};
    stk_raddr  = SAW'(sp - HAW'(1));
    code_we    = 1'b0;
    code_waddr = s[SAW-1:0];
    code_wdata = '0;
    cnt_raddr  = s[SAW-1:0];
    unique case (state)
      B_LOAD_WR: begin
        code_we = 1'b1;
        if (cnt_rdata != '0) begin
          heap_we    = 1'b1;
          heap_waddr = n + HAW'(1);
          heap_wdata = '{weight: WEIGHT_W'(cnt_rdata), node: NODE_W'(s)};
        end
      end
      H_CHK: heap_raddr = c2[HAW-1:0];
      H_RD_R: heap_raddr = c2p1[HAW-1:0];
      H_CMP: begin
        heap_we    = c_sel.weight < e.weight;
        heap_wdata = c_sel;
      end
      H_PLACE: heap_we = 1'b1;
      M_CHECK, M_SECOND, T_START: heap_raddr = HAW'(1);
      M_POP1: heap_raddr = n;
      M_POP2: begin
        heap_we    = 1'b1;
        heap_waddr = HAW'(1);
        heap_wdata = heap_q;
      end
      M_INS: begin
        node_we    = 1'b1;
        heap_we    = 1'b1;
        heap_waddr = n + HAW'(1);
        heap_wdata = '{weight: sum_sat, node: NODE_W'(LEAF_IDS) + NODE_W'(nxt)};
      end
      T_ROOT: begin
        stk_we    = 1'b1;
        stk_wdata = {heap_q.node, DEPTH_W'(0), CW'(0)};
      end
      T_PUSH_R: stk_we = 1'b1;
      T_PUSH_L: begin
        stk_we    = 1'b1;
        stk_wdata = {node_q[2*NODE_W-1:NODE_W], depth_inc, cur_code[CW-2:0], 1'b0};
      end
      T_LEAF_RD: cnt_raddr = cur_node[SAW-1:0];
      T_LEAF: begin
        cnt_raddr  = cur_node[SAW-1:0];
        code_we    = cur_depth <= DEPTH_W'(LEN_LIMIT);
        code_waddr = cur_node[SAW-1:0];
        code_wdata = {cur_depth[LEN_W-1:0], cur_code};
      end
      C_CLEAR: code_we = 1'b1;
      default: ;
    endcase
  end

  assign res = '{done: state == B_DONE, status: res_status, pad: res_pad};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        s        <= '0;
        n        <= '0;
        nxt      <= '0;
        sp       <= '0;
        too_long <= 1'b0;
        acc      <= '0;
      end
      B_LOAD_WR: begin
        s <= s + (SAW+1)'(1);
        if (cnt_rdata != '0) n <= n + HAW'(1);
      end
      B_LOAD_END: begin
        ret        <= M_CHECK;
        res_status <= ST_EMPTY;
        res_pad    <= '0;
      end
      H_START: i <= half;
      H_WT_I: begin
        e <= heap_q;
        p <= i;
      end
      H_RD_R: lch <= heap_q;
      H_CMP: if (c_sel.weight < e.weight) p <= c_pos;
      H_PLACE: i <= i - HAW'(1);
      M_CHECK: second <= 1'b0;
      M_SECOND: second <= 1'b1;
      M_POP1: begin
        if (second) r_ent <= heap_q;
        else l_ent <= heap_q;
      end
      M_POP2: begin
        n   <= n - HAW'(1);
        ret <= second ? M_INS : M_SECOND;
      end
      M_INS: begin
        n   <= n + HAW'(1);
        nxt <= nxt + INT_AW'(1);
        ret <= M_CHECK;
      end
      T_ROOT: sp <= HAW'(1);
      T_POP: if (sp != '0) sp <= sp - HAW'(1);
      T_VISIT: begin
        cur_node  <= stk_node;
        cur_depth <= stk_depth;
        cur_code  <= stk_code;
      end
      T_PUSH_R, T_PUSH_L: sp <= sp + HAW'(1);
      T_LEAF: begin
        if (cur_depth > DEPTH_W'(LEN_LIMIT)) too_long <= 1'b1;
        acc <= acc + 3'(cnt_rdata[2:0] * cur_depth[2:0]);
      end
      T_END: begin
        s          <= '0;
        res_status <= too_long ? ST_TOO_LONG : ST_OK;
        res_pad    <= too_long ? 3'd0 : 3'(-acc);
      end
      C_CLEAR: s <= s + (SAW+1)'(1);
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/hbc_pack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbc_pack
// Bit packer: shifts a code in one bit a cycle while no completed byte waits
// for emit_ready, msb first, and hands out each completed byte.
// ----------------------------------------------------------------------------
module hbc_pack import hbc_pkg::*; #(
  parameter int CW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             preset,
  input  logic [2:0]       pad,
  input  logic             start,
  input  logic [LEN_W-1:0] len,
  input  logic [CW-1:0]    code,
  input  logic             emit_ready,
  output hbc_emit_t        emit,
  output logic             done
);

  localparam int CIW = (CW > 1) ? $clog2(CW) : 1;

  pk_state_t state, state_next;

  logic [7:0]       sreg;
  logic [3:0]       fill;
  logic [LEN_W-1:0] remain;
  logic [CW-1:0]    word;
  logic [2:0]       nbytes, sent;
  logic             full;
  logic [CIW-1:0]   idx;
  logic [LEN_W:0]   span;

  assign full = fill == 4'd8;
  assign idx  = CIW'(remain - LEN_W'(1));
  assign span = (LEN_W+1)'(fill) + (LEN_W+1)'(len);

  always_comb begin
    state_next = state;
    unique case (state)
      P_IDLE:  if (start) state_next = P_SHIFT;
      P_SHIFT: if (!full && remain == '0) state_next = P_IDLE;
      default: state_next = P_IDLE;
    endcase
  end

  always_comb begin
    emit = '{valid: 1'b0, data: sreg, last: (sent + 3'd1) == nbytes};
    done = 1'b0;
    unique case (state)
      P_SHIFT: begin
        emit.valid = full;
        done       = !full && remain == '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      sreg  <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (preset) begin
        sreg <= '0;
        fill <= 4'(pad);
      end else if (state == P_SHIFT) begin
        if (full) begin
          if (emit_ready) fill <= '0;
        end else if (remain != '0) begin
          sreg <= {sreg[6:0], word[idx]};
          fill <= fill + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == P_IDLE && start) begin
      word   <= code;
      remain <= len;
      nbytes <= 3'(span >> 3);
      sent   <= '0;
    end else if (state == P_SHIFT) begin
      if (full) begin
        if (emit_ready) sent <= sent + 3'd1;
      end else if (remain != '0) begin
        remain <= remain - LEN_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* src/huffman_byte_compressor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_byte_compressor
// Two-pass static Huffman compressor over a byte alphabet.
// ----------------------------------------------------------------------------
// One item at a time. A count item is a read-modify-write of the
// histogram RAM. An encode item shifts its code through the packer one
// bit per cycle, and the packer holds while a finished byte waits for
// result_ready. A build item is the long one: it loads the heap, then
// every re-heapify walks all inner heap nodes through the single read
// port of the heap RAM, and it runs 3*(n-1)+1 times for n present
// symbols; then the tree walk assigns the codes, and an overlong code
// adds a sweep clearing the code table. No clearing pass follows reset:
// histogram entries carry valid bits.
// ----------------------------------------------------------------------------
module huffman_byte_compressor import hbc_pkg::*; #(
  parameter int SYMBOLS      = 256,
  parameter int MAX_CODE_LEN = 32,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  hbc_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output hbc_out_t result
);

  localparam int LEN_LIMIT = (MAX_CODE_LEN < LEN_CAP) ? MAX_CODE_LEN : LEN_CAP;
  localparam int SAW       = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CW        = LEN_LIMIT;
  localparam int CODE_W    = LEN_W + CW;

  top_state_t state, state_next;

  logic [7:0]             cur_byte;
  logic                   in_range, item_in_range;
  logic                   slot_free;

  // histogram
  logic [SYMBOLS-1:0]     cnt_valid;
  logic                   cnt_vq;
  logic                   cnt_we;
  logic [SAW-1:0]         cnt_raddr, bld_cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_val, cnt_inc;

  // code table
  logic                   code_we;
  logic [SAW-1:0]         code_waddr;
  logic [CODE_W-1:0]      code_wdata, code_q;
  logic [LEN_W-1:0]       code_len, len_eff;

  hbc_build_res_t         bld_res, bld_hold;
  logic                   bld_start;

  logic                   pk_start, pk_preset, pk_done;
  hbc_emit_t              pk_emit;

  assign in_range      = {1'b0, cur_byte} < 9'(SYMBOLS);
  assign item_in_range = {1'b0, item.data_byte} < 9'(SYMBOLS);
  assign slot_free     = !result_valid || result_ready;
  assign cnt_raddr     = (state == S_BUILD) ? bld_cnt_raddr : cur_byte[SAW-1:0];
  assign cnt_val       = cnt_vq ? cnt_q : '0;
  // saturating increment
  assign cnt_inc       = (&cnt_val) ? cnt_val : cnt_val + COUNT_WIDTH'(1);
  assign code_len      = code_q[CODE_W-1 -: LEN_W];
  assign len_eff       = (in_range && code_len <= LEN_W'(LEN_LIMIT)) ? code_len : '0;

  hbc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SYMBOLS)) u_count (
    .clk(clk), .we(cnt_we), .waddr(cur_byte[SAW-1:0]), .wdata(cnt_inc),
    .raddr(cnt_raddr), .rdata(cnt_q)
  );

  hbc_ram #(.WIDTH(CODE_W), .DEPTH(SYMBOLS)) u_code (
    .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
    .raddr(cur_byte[SAW-1:0]), .rdata(code_q)
  );

  hbc_build #(.SYMBOLS(SYMBOLS), .COUNT_WIDTH(COUNT_WIDTH), .LEN_LIMIT(LEN_LIMIT)) u_build (
    .clk(clk), .rst(rst), .start(bld_start),
    .cnt_raddr(bld_cnt_raddr), .cnt_rdata(cnt_val),
    .code_we(code_we), .code_waddr(code_waddr), .code_wdata(code_wdata),
    .res(bld_res)
  );

  hbc_pack #(.CW(CW)) u_pack (
    .clk(clk), .rst(rst), .preset(pk_preset), .pad(bld_hold.pad),
    .start(pk_start), .len(len_eff), .code(code_q[CW-1:0]),
    .emit_ready(slot_free), .emit(pk_emit), .done(pk_done)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          unique case (item.kind)
            KIND_COUNT:  if (item_in_range) state_next = S_CNT_RD;
            KIND_BUILD:  state_next = S_BUILD;
            KIND_ENCODE: state_next = S_ENC_RD;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_CNT_RD:    state_next = S_CNT_WR;
      S_CNT_WR:    state_next = S_IDLE;
      S_BUILD:     if (bld_res.done) state_next = S_BUILD_OUT;
      S_BUILD_OUT: if (slot_free) state_next = S_IDLE;
      S_ENC_RD:    state_next = S_ENC_GO;
      S_ENC_GO:    state_next = S_ENC_RUN;
      S_ENC_RUN:   if (pk_done) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    bld_start  = 1'b0;
    cnt_we     = 1'b0;
    pk_start   = 1'b0;
    pk_preset  = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        bld_start  = item_valid && item.kind == KIND_BUILD;
      end
      S_CNT_WR:    cnt_we    = 1'b1;
      S_BUILD_OUT: pk_preset = slot_free;
      S_ENC_GO:    pk_start  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_we) cnt_valid[cur_byte[SAW-1:0]] <= 1'b1;
      if (state == S_BUILD_OUT && slot_free) begin
        result_valid <= 1'b1;
      end else if (pk_emit.valid && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_vq <= cnt_valid[cnt_raddr];
    if (item_valid && item_ready) cur_byte <= item.data_byte;
    if (bld_res.done) bld_hold <= bld_res;
    if (state == S_BUILD_OUT && slot_free) begin
      result <= '{out_byte: 8'd0, byte_valid: 1'b0, pad_bits: bld_hold.pad,
                  status: bld_hold.status, last: 1'b1};
    end else if (pk_emit.valid && slot_free) begin
      result <= '{out_byte: pk_emit.data, byte_valid: 1'b1, pad_bits: 3'd0,
                  status: ST_OK, last: pk_emit.last};
    end
  end

`ifndef SYNTHESIS
  a_build_done_in_build: assert property (@(posedge clk) disable iff (rst)
    bld_res.done |-> state == S_BUILD)
    else $error("build finished outside a build item");

  a_emit_in_encode: assert property (@(posedge clk) disable iff (rst)
    pk_emit.valid |-> state == S_ENC_RUN)
    else $error("packer offered a byte outside an encode item");

  a_build_result_form: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUILD_OUT && slot_free) |=>
      (result_valid && result.last && !result.byte_valid))
    else $error("build result not presented as a single last transfer");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> in_range)
    else $error("histogram written for an out of range symbol");
`endif

endmodule
`default_nettype wire
